// File: design/lpg_pkg.sv
// Package for the load pressure governor: codes, reset values and the
// structs used by the modules; the channel interfaces import it. No dependencies.
package lpg_pkg;

  // Action codes carried by each input item.
  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_CULL   = 2'd1;
  localparam logic [1:0] ACT_SHED   = 2'd2;
  localparam logic [1:0] ACT_QUERY  = 2'd3;

  // Pressure level codes.
  localparam logic [1:0] LVL_NORMAL = 2'd0;
  localparam logic [1:0] LVL_SOFT   = 2'd1;
  localparam logic [1:0] LVL_HARD   = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFT_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HARD_THR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CULL_CD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHED_CD   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFT_CAP  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_CAP = 3'd7;

  localparam int unsigned CFG_DATA_W = 32;

  // Configuration reset values.
  localparam logic        RST_ENABLED   = 1'b1;
  localparam logic [15:0] RST_SOFT_THR  = 16'd110;
  localparam logic [15:0] RST_HARD_THR  = 16'd180;
  localparam logic [31:0] RST_SUSTAIN   = 32'd10000;
  localparam logic [31:0] RST_CULL_CD   = 32'd20000;
  localparam logic [31:0] RST_SHED_CD   = 32'd5000;
  localparam logic [9:0]  RST_SOFT_CAP  = 10'd20;
  localparam logic [9:0]  RST_TOTAL_CAP = 10'd160;

  typedef struct packed {
    logic        governor_enabled;
    logic [15:0] soft_threshold_ms;
    logic [15:0] hard_threshold_ms;
    logic [31:0] hard_sustain_ms;
    logic [31:0] cull_cooldown_ms;
    logic [31:0] shed_cooldown_ms;
    logic [9:0]  soft_bot_cap;
    logic [9:0]  total_bot_cap;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now_ms;
    logic [15:0] sample_ms;
    logic [9:0]  match_bots;
    logic [9:0]  active_bots_total;
  } item_t;

  typedef struct packed {
    logic [1:0]  pressure_level;
    logic [15:0] average_ms;
    logic        may_add_bot;
    logic        may_cull;
    logic        may_shed;
  } result_t;

endpackage

// File: design/lpg_in_if.sv
// Input item channel of the load pressure governor.
// Imports lpg_pkg, though its field widths are written out as numbers.
interface lpg_in_if import lpg_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] now_ms;
  logic [15:0] sample_ms;
  logic [9:0]  match_bots;
  logic [9:0]  active_bots_total;

  modport source (output valid, action, now_ms, sample_ms, match_bots, active_bots_total,
                  input ready);
  modport sink (input valid, action, now_ms, sample_ms, match_bots, active_bots_total,
                output ready);
endinterface

// File: design/lpg_out_if.sv
// Result channel of the load pressure governor.
// Imports lpg_pkg, though its field widths are written out as numbers.
interface lpg_out_if import lpg_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  pressure_level;
  logic [15:0] average_ms;
  logic        may_add_bot;
  logic        may_cull;
  logic        may_shed;

  modport source (output valid, pressure_level, average_ms, may_add_bot, may_cull, may_shed,
                  input ready);
  modport sink (input valid, pressure_level, average_ms, may_add_bot, may_cull, may_shed,
                output ready);
endinterface

// File: design/lpg_cfg_if.sv
// Configuration write channel of the load pressure governor.
// Depends on lpg_pkg for the index and data widths.
interface lpg_cfg_if import lpg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/lpg_cfg_regs.sv
// Configuration register file of the load pressure governor.
// Depends on lpg_pkg and lpg_cfg_if.
module lpg_cfg_regs import lpg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lpg_cfg_if.sink    cfg_if,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Writes are always taken.
  assign cfg_if.ready = 1'b1;

  // Register write decode; each register keeps the low bits of the data.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_ENABLED:   cfg_nxt.governor_enabled  = cfg_if.data[0];
        CFG_SOFT_THR:  cfg_nxt.soft_threshold_ms = cfg_if.data[15:0];
        CFG_HARD_THR:  cfg_nxt.hard_threshold_ms = cfg_if.data[15:0];
        CFG_SUSTAIN:   cfg_nxt.hard_sustain_ms   = cfg_if.data[31:0];
        CFG_CULL_CD:   cfg_nxt.cull_cooldown_ms  = cfg_if.data[31:0];
        CFG_SHED_CD:   cfg_nxt.shed_cooldown_ms  = cfg_if.data[31:0];
        CFG_SOFT_CAP:  cfg_nxt.soft_bot_cap      = cfg_if.data[9:0];
        CFG_TOTAL_CAP: cfg_nxt.total_bot_cap     = cfg_if.data[9:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.governor_enabled  <= RST_ENABLED;
      cfg_r.soft_threshold_ms <= RST_SOFT_THR;
      cfg_r.hard_threshold_ms <= RST_HARD_THR;
      cfg_r.hard_sustain_ms   <= RST_SUSTAIN;
      cfg_r.cull_cooldown_ms  <= RST_CULL_CD;
      cfg_r.shed_cooldown_ms  <= RST_SHED_CD;
      cfg_r.soft_bot_cap      <= RST_SOFT_CAP;
      cfg_r.total_bot_cap     <= RST_TOTAL_CAP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/lpg_core.sv
// Governor state and the single-pass evaluation of one item: average fold,
// pressure level, hard start time, cull/shed times and the three verdicts.
// Depends on lpg_pkg.
module lpg_core import lpg_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  item_t   item,
  input  logic    fire,
  output result_t res
);

  logic [15:0] avg_r, avg_nxt;
  logic [1:0]  lvl_r, lvl_nxt;
  logic [31:0] hs_r, hs_nxt;
  logic [31:0] cull_r, cull_nxt;
  logic [31:0] shed_r, shed_nxt;

  logic        is_sample;
  logic [15:0] diff_up, diff_dn, avg_fold;
  logic [1:0]  lvl_fold;
  logic [31:0] now_nz;
  logic        hs_from_now;
  logic [31:0] sus_old, sus_now, sus_end;
  logic        sustained;
  logic [31:0] cull_end, shed_end;
  logic        cull_ok, shed_ok;
  logic        is_hard;
  logic [10:0] bot_sum;
  logic        over_total;
  logic        admit;

  assign is_sample = (item.action == ACT_SAMPLE) && cfg.governor_enabled;

  // Exponential average: take the sample as is while the average is zero, else step by one eighth.
  always_comb begin
    diff_up = item.sample_ms - avg_r;
    diff_dn = avg_r - item.sample_ms;
    if (avg_r == '0) begin
      avg_fold = item.sample_ms;
    end else if (item.sample_ms >= avg_r) begin
      avg_fold = avg_r + (diff_up >> 3);
    end else begin
      avg_fold = avg_r - (diff_dn >> 3);
    end
  end

  // Hard threshold is tested before soft.
  always_comb begin
    if (avg_fold >= cfg.hard_threshold_ms) begin
      lvl_fold = LVL_HARD;
    end else if (avg_fold >= cfg.soft_threshold_ms) begin
      lvl_fold = LVL_SOFT;
    end else begin
      lvl_fold = LVL_NORMAL;
    end
  end

  // A hard start at time zero is kept as one, since zero means not in hard.
  assign now_nz = {item.now_ms[31:1], item.now_ms[0] | (item.now_ms == '0)};

  // Next state of the average, level and hard start.
  always_comb begin
    avg_nxt     = avg_r;
    lvl_nxt     = lvl_r;
    hs_nxt      = hs_r;
    hs_from_now = 1'b0;
    if (is_sample) begin
      avg_nxt = avg_fold;
      lvl_nxt = lvl_fold;
      if (lvl_fold == LVL_HARD) begin
        if (hs_r == '0) begin
          hs_nxt      = now_nz;
          hs_from_now = 1'b1;
        end
      end else begin
        hs_nxt = '0;
      end
    end
  end

  // Cull and shed times are noted whether or not the governor is enabled.
  assign cull_nxt = (item.action == ACT_CULL) ? item.now_ms : cull_r;
  assign shed_nxt = (item.action == ACT_SHED) ? item.now_ms : shed_r;

  // Sums for the permission tests run in parallel with the state selection.
  assign sus_old  = hs_r + cfg.hard_sustain_ms;
  assign sus_now  = now_nz + cfg.hard_sustain_ms;
  assign sus_end  = hs_from_now ? sus_now : sus_old;
  assign cull_end = ((item.action == ACT_CULL) ? item.now_ms : cull_r) + cfg.cull_cooldown_ms;
  assign shed_end = ((item.action == ACT_SHED) ? item.now_ms : shed_r) + cfg.shed_cooldown_ms;

  assign is_hard   = cfg.governor_enabled && (lvl_nxt == LVL_HARD);
  assign sustained = is_hard && (hs_nxt != '0) && (item.now_ms >= sus_end);
  assign cull_ok   = (cull_nxt == '0) || (item.now_ms >= cull_end);
  assign shed_ok   = (shed_nxt == '0) || (item.now_ms >= shed_end);

  // Admission: always when disabled; else the overall cap first, then the pressure level.
  assign bot_sum    = {1'b0, item.active_bots_total} + {1'b0, item.match_bots};
  assign over_total = (cfg.total_bot_cap != '0) && (bot_sum >= {1'b0, cfg.total_bot_cap});

  always_comb begin
    if (!cfg.governor_enabled) begin
      admit = 1'b1;
    end else if (over_total) begin
      admit = 1'b0;
    end else begin
      case (lvl_nxt)
        LVL_HARD: admit = 1'b0;
        LVL_SOFT: admit = item.match_bots < cfg.soft_bot_cap;
        default:  admit = 1'b1;
      endcase
    end
  end

  assign res.pressure_level = cfg.governor_enabled ? lvl_nxt : LVL_NORMAL;
  assign res.average_ms     = avg_nxt;
  assign res.may_add_bot    = admit;
  assign res.may_cull       = sustained && cull_ok;
  assign res.may_shed       = sustained && shed_ok;

  // State registers advance once per fire, as the evaluated item moves on to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r  <= '0;
      lvl_r  <= LVL_NORMAL;
      hs_r   <= '0;
      cull_r <= '0;
      shed_r <= '0;
    end else if (fire) begin
      avg_r  <= avg_nxt;
      lvl_r  <= lvl_nxt;
      hs_r   <= hs_nxt;
      cull_r <= cull_nxt;
      shed_r <= shed_nxt;
    end
  end

  // A hard start time is held exactly while the stored level is hard.
  a_hard_start: assert property (@(posedge clk) disable iff (!rst_n)
    (lvl_r == LVL_HARD) == (hs_r != '0))
    else $error("hard start time out of step with level");

  // A sample taken while disabled leaves the average and level alone.
  a_disabled_sample: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !cfg.governor_enabled |=> $stable(avg_r) && $stable(lvl_r))
    else $error("disabled sample changed the average");

  // Items other than samples never move the average.
  a_nonsample_avg: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item.action != ACT_SAMPLE) |=> $stable(avg_r))
    else $error("non-sample item changed the average");

endmodule

// File: design/load_pressure_governor_top.sv
// Load pressure governor: input register, single-pass evaluation, result register.
// An accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while reports are taken; output stalls back up both stages.
// Reset (synchronous, rst_n low) empties both stages, clears the average, level,
// hard start and cull/shed times, and loads the default configuration.
// Depends on lpg_pkg, lpg_in_if, lpg_out_if, lpg_cfg_if, lpg_cfg_regs and lpg_core.
module load_pressure_governor_top import lpg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  lpg_in_if.sink    in_if,
  lpg_out_if.source out_if,
  lpg_cfg_if.sink   cfg_if
);

  cfg_t    cfg;
  item_t   s1_item_r;
  logic    s1_valid_r, s1_valid_nxt;
  result_t core_res;
  result_t out_res_r;
  logic    out_valid_r, out_valid_nxt;
  logic    out_free;
  logic    s1_adv;
  logic    in_xfer;

  lpg_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  // Stage handshake: the result register frees when empty or being drained.
  assign out_free     = !out_valid_r || out_if.ready;
  assign s1_adv       = s1_valid_r && out_free;
  assign in_if.ready  = !s1_valid_r || out_free;
  assign in_xfer      = in_if.valid && in_if.ready;

  assign s1_valid_nxt  = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.action            <= in_if.action;
      s1_item_r.now_ms            <= in_if.now_ms;
      s1_item_r.sample_ms         <= in_if.sample_ms;
      s1_item_r.match_bots        <= in_if.match_bots;
      s1_item_r.active_bots_total <= in_if.active_bots_total;
    end
    if (s1_adv) begin
      out_res_r <= core_res;
    end
  end

  lpg_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (s1_item_r),
    .fire  (s1_adv),
    .res   (core_res)
  );

  assign out_if.valid          = out_valid_r;
  assign out_if.pressure_level = out_res_r.pressure_level;
  assign out_if.average_ms     = out_res_r.average_ms;
  assign out_if.may_add_bot    = out_res_r.may_add_bot;
  assign out_if.may_cull       = out_res_r.may_cull;
  assign out_if.may_shed       = out_res_r.may_shed;

  // An item leaving the input register always lands in the result register.
  a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("item lost between stages");

  // Cull or shed permission only comes with a hard level.
  a_perm_hard: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.may_cull || out_res_r.may_shed) |->
    out_res_r.pressure_level == LVL_HARD)
    else $error("permission granted outside hard pressure");

  // Hard pressure never admits a bot.
  a_hard_no_admit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.pressure_level == LVL_HARD) |-> !out_res_r.may_add_bot)
    else $error("bot admitted under hard pressure");

  // Both stages are empty after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !out_valid_r)
    else $error("stage valid after reset");

endmodule

// File: verif/lpg_checker.sv
// Checker for the load pressure governor: watches the item, report and register channels,
// keeps its own copy of the governor state and compares every report as it is transferred.
// Depends on lpg_pkg and the lpg_in_if, lpg_out_if and lpg_cfg_if interfaces.
module lpg_checker import lpg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  lpg_in_if           items,
  lpg_out_if          reports,
  lpg_cfg_if          regs,
  output int unsigned mismatch_count,
  output int unsigned reports_awaited
);

  // Local copy of the settings and of the governor state.
  cfg_t        settings;
  logic [15:0] avg_ms;
  logic [1:0]  level;
  logic [31:0] hard_since_ms;
  logic [31:0] cull_at_ms;
  logic [31:0] shed_at_ms;
  result_t     reports_due[$];

  // Cull and shed need hard pressure held for the sustain time and the cooldown to be over.
  function automatic logic action_allowed(logic [31:0] now, logic [31:0] last_ms,
                                          logic [31:0] cooldown);
    logic [31:0] sustained_at;
    logic [31:0] cooled_at;
    sustained_at = hard_since_ms + settings.hard_sustain_ms;
    cooled_at = last_ms + cooldown;
    if (!settings.governor_enabled || level != LVL_HARD) return 1'b0;
    if (hard_since_ms == '0 || now < sustained_at) return 1'b0;
    return (last_ms == '0) || (now >= cooled_at);
  endfunction

  // Applies one item to the state and works out the report it should produce.
  function automatic result_t govern(item_t it);
    result_t     r;
    logic [15:0] gap_ms;
    logic [10:0] crowd;
    if (it.action == ACT_SAMPLE && settings.governor_enabled) begin
      // A zero average takes the first sample whole, otherwise it moves an eighth of the way.
      if (avg_ms == '0) begin
        avg_ms = it.sample_ms;
      end else if (it.sample_ms >= avg_ms) begin
        gap_ms = it.sample_ms - avg_ms;
        avg_ms = avg_ms + (gap_ms >> 3);
      end else begin
        gap_ms = avg_ms - it.sample_ms;
        avg_ms = avg_ms - (gap_ms >> 3);
      end
      if (avg_ms >= settings.hard_threshold_ms) level = LVL_HARD;
      else if (avg_ms >= settings.soft_threshold_ms) level = LVL_SOFT;
      else level = LVL_NORMAL;
      // Zero means not in hard pressure, so hard pressure starting at time zero is kept as one.
      if (level != LVL_HARD) hard_since_ms = '0;
      else if (hard_since_ms == '0) hard_since_ms = (it.now_ms != '0) ? it.now_ms : 32'd1;
    end else if (it.action == ACT_CULL) begin
      cull_at_ms = it.now_ms;
    end else if (it.action == ACT_SHED) begin
      shed_at_ms = it.now_ms;
    end

    r.pressure_level = settings.governor_enabled ? level : LVL_NORMAL;
    r.average_ms = avg_ms;

    // Admission: always when disabled; else the overall cap comes first, then the pressure level decides.
    crowd = {1'b0, it.match_bots} + {1'b0, it.active_bots_total};
    if (!settings.governor_enabled) r.may_add_bot = 1'b1;
    else if (settings.total_bot_cap != '0 && crowd >= {1'b0, settings.total_bot_cap})
      r.may_add_bot = 1'b0;
    else if (level == LVL_HARD) r.may_add_bot = 1'b0;
    else if (level == LVL_SOFT) r.may_add_bot = it.match_bots < settings.soft_bot_cap;
    else r.may_add_bot = 1'b1;

    r.may_cull = action_allowed(it.now_ms, cull_at_ms, settings.cull_cooldown_ms);
    r.may_shed = action_allowed(it.now_ms, shed_at_ms, settings.shed_cooldown_ms);
    return r;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  // All three channels are sampled at the rising edge; a report is checked before the
  // item of the same edge is predicted.
  always @(posedge clk) begin
    result_t want;
    item_t   seen;
    if (!rst_n) begin
      settings = '{governor_enabled: RST_ENABLED, soft_threshold_ms: RST_SOFT_THR,
                   hard_threshold_ms: RST_HARD_THR, hard_sustain_ms: RST_SUSTAIN,
                   cull_cooldown_ms: RST_CULL_CD, shed_cooldown_ms: RST_SHED_CD,
                   soft_bot_cap: RST_SOFT_CAP, total_bot_cap: RST_TOTAL_CAP};
      avg_ms = '0;
      level = LVL_NORMAL;
      hard_since_ms = '0;
      cull_at_ms = '0;
      shed_at_ms = '0;
      reports_due.delete();
      mismatch_count = 0;
    end else begin
      if (reports.valid && reports.ready) begin
        if (reports_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: report transfer with none expected, got level %0d average %0d",
                   $time, reports.pressure_level, reports.average_ms);
        end else begin
          want = reports_due.pop_front();
          check_field("pressure_level", 32'(want.pressure_level),
                      32'(reports.pressure_level));
          check_field("average_ms", 32'(want.average_ms), 32'(reports.average_ms));
          check_field("may_add_bot", 32'(want.may_add_bot), 32'(reports.may_add_bot));
          check_field("may_cull", 32'(want.may_cull), 32'(reports.may_cull));
          check_field("may_shed", 32'(want.may_shed), 32'(reports.may_shed));
        end
      end

      if (regs.valid && regs.ready) begin
        case (regs.index)
          CFG_ENABLED:   settings.governor_enabled = regs.data[0];
          CFG_SOFT_THR:  settings.soft_threshold_ms = regs.data[15:0];
          CFG_HARD_THR:  settings.hard_threshold_ms = regs.data[15:0];
          CFG_SUSTAIN:   settings.hard_sustain_ms = regs.data;
          CFG_CULL_CD:   settings.cull_cooldown_ms = regs.data;
          CFG_SHED_CD:   settings.shed_cooldown_ms = regs.data;
          CFG_SOFT_CAP:  settings.soft_bot_cap = regs.data[9:0];
          CFG_TOTAL_CAP: settings.total_bot_cap = regs.data[9:0];
          default: ;
        endcase
      end

      if (items.valid && items.ready) begin
        seen = '{items.action, items.now_ms, items.sample_ms, items.match_bots,
                 items.active_bots_total};
        reports_due.push_back(govern(seen));
      end
    end
    reports_awaited = reports_due.size();
  end

endmodule

// File: verif/testbench.sv
// Top of the load pressure governor testbench: clock, reset, register phases, item stimulus
// and report back-pressure. Depends on lpg_pkg, the channel interfaces, the governor top
// level and lpg_checker, which does all prediction and comparison.
module testbench;
  import lpg_pkg::*;

  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 188;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned mismatch_count;
  int unsigned reports_awaited;

  // Settings of the current phase and the running wall clock of the items.
  cfg_t        plan;
  logic [31:0] clock_ms;
  int          time_step;
  bit          brisk_sender;
  bit          brisk_receiver;
  bit          stall_request;

  lpg_in_if  in_ch ();
  lpg_out_if out_ch ();
  lpg_cfg_if cfg_ch ();

  load_pressure_governor_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  lpg_checker governor_watch (
    .clk             (clk),
    .rst_n           (rst_n),
    .items           (in_ch),
    .reports         (out_ch),
    .regs            (cfg_ch),
    .mismatch_count  (mismatch_count),
    .reports_awaited (reports_awaited)
  );

  always #5 clk = ~clk;

  // One register write; the channel is dropped again after the transfer.
  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Offers one item after a random gap (none while the sender is brisk) and returns once it has been transferred.
  task automatic send_item(item_t it);
    int gap;
    gap = brisk_sender ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.action <= it.action;
    in_ch.now_ms <= it.now_ms;
    in_ch.sample_ms <= it.sample_ms;
    in_ch.match_bots <= it.match_bots;
    in_ch.active_bots_total <= it.active_bots_total;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Random item: time mostly moves forward in steps that suit the phase, samples mostly
  // straddle the thresholds so the level keeps changing, bot counts mostly run up to about the caps.
  function automatic item_t draw_item();
    item_t it;
    int    pick;
    int    sample_span;
    sample_span = plan.hard_threshold_ms * 2 + 16;
    if (sample_span > 65535) sample_span = 65535;
    case ($urandom_range(0, 19))
      0: clock_ms = $urandom;
      1: clock_ms = 32'd0;
      default: clock_ms = clock_ms + $urandom_range(0, time_step);
    endcase
    it.now_ms = clock_ms;

    pick = $urandom_range(0, 99);
    if (pick < 50) it.action = ACT_SAMPLE;
    else if (pick < 62) it.action = ACT_CULL;
    else if (pick < 74) it.action = ACT_SHED;
    else it.action = ACT_QUERY;

    pick = $urandom_range(0, 99);
    if (pick == 0) it.sample_ms = 16'($urandom);
    else if (pick == 1) it.sample_ms = 16'hFFFF;
    else if (pick < 6) it.sample_ms = 16'd0;
    else it.sample_ms = 16'($urandom_range(0, sample_span));

    if ($urandom_range(0, 2) == 0) begin
      it.match_bots = 10'($urandom);
      it.active_bots_total = 10'($urandom);
    end else begin
      it.match_bots = 10'($urandom_range(0, plan.soft_bot_cap + 2));
      it.active_bots_total = 10'($urandom_range(0, plan.total_bot_cap));
    end
    return it;
  endfunction

  // Report side: a random hold-off before each transfer, idle-free stretches now and then,
  // and one long hold-off on request so that the block backs up into its input.
  initial begin
    int gap;
    int served;
    out_ch.ready = 1'b0;
    served = 0;
    brisk_receiver = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = brisk_receiver ? 0 : $urandom_range(0, 8);
      if (stall_request) begin
        gap = 80;
        stall_request = 1'b0;
      end
      if (gap > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      served++;
      if (served % 64 == 0) brisk_receiver = ($urandom_range(0, 3) == 0);
    end
  end

  // Item and register stimulus, phase by phase, then the verdict.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_QUERY;
    in_ch.now_ms = '0;
    in_ch.sample_ms = '0;
    in_ch.match_bots = '0;
    in_ch.active_bots_total = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_ENABLED;
    cfg_ch.data = '0;
    stall_request = 1'b0;
    brisk_sender = 1'b0;
    clock_ms = 32'd100;
    time_step = 1500;
    plan = '{governor_enabled: RST_ENABLED, soft_threshold_ms: RST_SOFT_THR,
             hard_threshold_ms: RST_HARD_THR, hard_sustain_ms: RST_SUSTAIN,
             cull_cooldown_ms: RST_CULL_CD, shed_cooldown_ms: RST_SHED_CD,
             soft_bot_cap: RST_SOFT_CAP, total_bot_cap: RST_TOTAL_CAP};
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        case (phase)
          1: begin
            plan = '{1'b1, 16'd100, 16'd200, 32'd50, 32'd100, 32'd30, 10'd5, 10'd40};
            time_step = 20;
          end
          2: begin
            plan = '{1'b1, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0, 10'd0, 10'd0};
            time_step = 4;
          end
          3: begin
            plan = '{1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     10'h3FF, 10'h3FF};
            time_step = 32'h1000_0000;
          end
          4: begin
            plan = '{1'b0, 16'd120, 16'd160, 32'd20, 32'd40, 32'd10, 10'd8, 10'd100};
            time_step = 25;
          end
          5: begin
            // Soft threshold above the hard one: hard is tested first.
            plan = '{1'b1, 16'd300, 16'd150, 32'd30, 32'd60, 32'd20, 10'd12, 10'h3FF};
            time_step = 30;
          end
          default: begin
            plan.governor_enabled = ($urandom_range(0, 4) != 0);
            plan.soft_threshold_ms = 16'($urandom_range(0, 400));
            plan.hard_threshold_ms = 16'($urandom_range(0, 600));
            plan.hard_sustain_ms = ($urandom_range(0, 5) == 0) ? $urandom
                                                                : $urandom_range(0, 300);
            plan.cull_cooldown_ms = ($urandom_range(0, 5) == 0) ? $urandom
                                                                 : $urandom_range(0, 300);
            plan.shed_cooldown_ms = ($urandom_range(0, 5) == 0) ? $urandom
                                                                 : $urandom_range(0, 300);
            plan.soft_bot_cap = 10'($urandom_range(0, 40));
            plan.total_bot_cap = ($urandom_range(0, 3) == 0) ? 10'($urandom)
                                                             : 10'($urandom_range(0, 120));
            time_step = 50;
          end
        endcase
        // Narrow registers get random upper data bits, which the block drops.
        write_setting(CFG_ENABLED, {31'($urandom), plan.governor_enabled});
        write_setting(CFG_SOFT_THR, {16'($urandom), plan.soft_threshold_ms});
        write_setting(CFG_HARD_THR, {16'($urandom), plan.hard_threshold_ms});
        write_setting(CFG_SUSTAIN, plan.hard_sustain_ms);
        write_setting(CFG_CULL_CD, plan.cull_cooldown_ms);
        write_setting(CFG_SHED_CD, plan.shed_cooldown_ms);
        write_setting(CFG_SOFT_CAP, {22'($urandom), plan.soft_bot_cap});
        write_setting(CFG_TOTAL_CAP, {22'($urandom), plan.total_bot_cap});
      end else begin
        // Directed opening under the reset settings: soft admission limits, the overall
        // cap, hard pressure starting at time zero, a cull noted at time zero, sustain and
        // cooldown edges, time sums that wrap, and extreme field values.
        send_item(item_t'{ACT_QUERY, 32'd0, 16'hFFFF, 10'd0, 10'd0});
        send_item(item_t'{ACT_SAMPLE, 32'd5, 16'd150, 10'd19, 10'd0});
        send_item(item_t'{ACT_QUERY, 32'd6, 16'd0, 10'd20, 10'd0});
        send_item(item_t'{ACT_QUERY, 32'd7, 16'd0, 10'd100, 10'd60});
        send_item(item_t'{ACT_QUERY, 32'd8, 16'd0, 10'd0, 10'd159});
        send_item(item_t'{ACT_CULL, 32'd0, 16'd0, 10'd0, 10'd0});
        send_item(item_t'{ACT_SAMPLE, 32'd0, 16'hFFFF, 10'd0, 10'd0});
        send_item(item_t'{ACT_QUERY, 32'd10000, 16'd0, 10'd0, 10'd0});
        send_item(item_t'{ACT_QUERY, 32'd10001, 16'd0, 10'd0, 10'd0});
        send_item(item_t'{ACT_CULL, 32'd10001, 16'd0, 10'd0, 10'd0});
        send_item(item_t'{ACT_SHED, 32'd12000, 16'd0, 10'd0, 10'd0});
        send_item(item_t'{ACT_QUERY, 32'd17000, 16'd0, 10'd0, 10'd0});
        send_item(item_t'{ACT_QUERY, 32'd30001, 16'd0, 10'd0, 10'd0});
        send_item(item_t'{ACT_SAMPLE, 32'd30002, 16'd0, 10'd0, 10'd0});
        send_item(item_t'{ACT_QUERY, 32'hFFFF_FFFF, 16'd0, 10'h3FF, 10'h3FF});
        send_item(item_t'{ACT_SHED, 32'hFFFF_FFFF, 16'd0, 10'd0, 10'd0});
        send_item(item_t'{ACT_QUERY, 32'h5555_5555, 16'hAAAA, 10'h155, 10'h2AA});
        send_item(item_t'{ACT_QUERY, 32'hAAAA_AAAA, 16'h5555, 10'h2AA, 10'h155});
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 50 == 0) brisk_sender = ($urandom_range(0, 3) == 0);
        // Long report hold-off while items keep coming back to back.
        if (phase == 1 && n == 60) begin
          stall_request = 1'b1;
          brisk_sender = 1'b1;
        end
        // Sender pause until every pending report has been transferred.
        if (phase == 1 && n == 120) begin
          release_input();
          wait (reports_awaited == 0);
        end
        send_item(draw_item());
      end
      release_input();
      wait (reports_awaited == 0);
    end

    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && reports_awaited == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
